@@ rtl/core/fpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed partition fit allocator package
// Shared sizes, operation and register codes, and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

  localparam int MAX_PARTITIONS = 32;
  localparam int SIZE_BITS      = 16;
  localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
  localparam int CNT_BITS       = 6;
  localparam int OP_BITS        = 2;
  localparam int POL_BITS       = 2;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ALLOC  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_NEWRUN = 2'd2;

  localparam logic [POL_BITS-1:0] POL_WORST = 2'd1;
  localparam logic [POL_BITS-1:0] POL_BEST  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARTS  = 2'd1;

  typedef struct packed {
    logic [OP_BITS-1:0]   opcode;
    logic [IDX_BITS-1:0]  entry_index;
    logic [SIZE_BITS-1:0] size_value;
  } fpfa_item_t;

  typedef struct packed {
    logic [POL_BITS-1:0] policy;
    logic [CNT_BITS-1:0] limit;
  } fpfa_cfg_t;

  typedef struct packed {
    logic                 allocated;
    logic [IDX_BITS-1:0]  chosen_partition;
    logic [SIZE_BITS-1:0] chosen_size;
    logic [SIZE_BITS-1:0] leftover;
  } fpfa_res_t;

endpackage

`default_nettype wire

@@ rtl/core/fixed_partition_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// Input transactions (opcode, entry_index, size_value) load a partition size,
// allocate a request or start a new run; each yields one output transaction
// (allocated, chosen_partition, chosen_size, leftover). Both channels move a
// transaction when valid is high and stall is low. The configuration channel
// writes policy_mode (index 0) and partitions_in_use (index 1) on valid and
// ready; ready is always high and both registers are sampled when a
// transaction is accepted, so write them only while nothing is in flight.
// A load, new run or unused opcode goes from acceptance straight to the finish
// state. An allocate scans N = min(partitions_in_use, 32) partitions,
// one a cycle through one registered read port and one compare and subtract
// unit, then finishes. One transaction is in flight at a time; in_stall stays
// high until the result has moved into the output register, so the next
// transaction can be accepted in the same cycle as the result shows.
// Reset clears the used marks, the registers and the output valid; partition
// sizes are undefined until loaded. While out_stall holds a result, the next
// transaction may be accepted and worked on, but its result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator
  import fpfa_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [OP_BITS-1:0]      opcode,
  input  wire logic [IDX_BITS-1:0]     entry_index,
  input  wire logic [SIZE_BITS-1:0]    size_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         allocated,
  output logic      [IDX_BITS-1:0]     chosen_partition,
  output logic      [SIZE_BITS-1:0]    chosen_size,
  output logic      [SIZE_BITS-1:0]    leftover,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CNT_BITS-1:0]     cfg_data
);

  logic [POL_BITS-1:0]  policy_mode;
  logic [CNT_BITS-1:0]  partitions_in_use;
  fpfa_cfg_t            cfg;
  fpfa_item_t           item;
  fpfa_res_t            res;
  fpfa_res_t            out_q;
  logic                 idle;
  logic                 ram_wr_en;
  logic [IDX_BITS-1:0]  ram_rd_addr;
  logic [SIZE_BITS-1:0] ram_rd_data;
  logic                 res_valid;
  logic                 res_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode       <= '0;
      partitions_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLICY: policy_mode       <= cfg_data[POL_BITS-1:0];
        CFG_PARTS:  partitions_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.policy = policy_mode;
    if (partitions_in_use > CNT_BITS'(MAX_PARTITIONS)) begin
      cfg.limit = CNT_BITS'(MAX_PARTITIONS);
    end else begin
      cfg.limit = partitions_in_use;
    end
  end

  assign item.opcode      = opcode;
  assign item.entry_index = entry_index;
  assign item.size_value  = size_value;
  assign in_stall         = !idle;

  fpfa_size_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (entry_index),
    .wr_data (size_value),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  fpfa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (in_valid),
    .item        (item),
    .cfg         (cfg),
    .idle        (idle),
    .ram_wr_en   (ram_wr_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign allocated        = out_q.allocated;
  assign chosen_partition = out_q.chosen_partition;
  assign chosen_size      = out_q.chosen_size;
  assign leftover         = out_q.leftover;

endmodule

`default_nettype wire

@@ rtl/core/fpfa_size_ram.sv @@
// ----------------------------------------------------------------------------
// Partition size memory
// One write port and one registered read port over the partition size table.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_size_ram
  import fpfa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [IDX_BITS-1:0]  wr_addr,
  input  wire logic [SIZE_BITS-1:0] wr_data,
  input  wire logic [IDX_BITS-1:0]  rd_addr,
  output logic      [SIZE_BITS-1:0] rd_data
);

  logic [SIZE_BITS-1:0] mem [MAX_PARTITIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/core/fpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Allocation sequencer
// Walks the partitions one a cycle through a single compare and subtract unit,
// keeps the used marks and commits the chosen partition.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_ctrl
  import fpfa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire fpfa_item_t           item,
  input  wire fpfa_cfg_t            cfg,
  output logic                      idle,
  output logic                      ram_wr_en,
  output logic      [IDX_BITS-1:0]  ram_rd_addr,
  input  wire logic [SIZE_BITS-1:0] ram_rd_data,
  output logic                      res_valid,
  input  wire logic                 res_take,
  output fpfa_res_t                 res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]              state;
  logic [CNT_BITS-1:0]     cnt;
  logic [CNT_BITS-1:0]     limit_q;
  logic [POL_BITS-1:0]     policy_q;
  logic [SIZE_BITS-1:0]    req;
  logic                    cmp_valid;
  logic [IDX_BITS-1:0]     cmp_idx;
  logic                    found;
  logic [IDX_BITS-1:0]     pick;
  logic [SIZE_BITS-1:0]    pick_size;
  logic [SIZE_BITS-1:0]    pick_left;
  logic [MAX_PARTITIONS-1:0] used;

  logic                    issue;
  logic                    fits;
  logic [SIZE_BITS-1:0]    left;
  logic                    take;
  logic                    accept;

  assign idle        = (state == ST_IDLE);
  assign accept      = idle && item_valid;
  assign ram_wr_en   = accept && (item.opcode == OP_LOAD);
  assign issue       = (state == ST_SCAN) && (cnt < limit_q);
  assign ram_rd_addr = cnt[IDX_BITS-1:0];

  always_comb begin
    fits = !used[cmp_idx] && (ram_rd_data >= req);
    left = ram_rd_data - req;
    if (!found) begin
      take = 1'b1;
    end else if (policy_q == POL_WORST) begin
      take = left > pick_left;
    end else if (policy_q == POL_BEST) begin
      take = left < pick_left;
    end else begin
      take = 1'b0;
    end
    take = take && fits && cmp_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      used      <= '0;
    end else begin
      cmp_valid <= issue;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            found <= 1'b0;
            if (item.opcode == OP_ALLOC) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
              if (item.opcode == OP_NEWRUN) begin
                used <= '0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (take) begin
            found <= 1'b1;
          end
          if (!issue && !cmp_valid) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (res_take) begin
            state <= ST_IDLE;
            if (found) begin
              used[pick] <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cnt[IDX_BITS-1:0];
    if (accept) begin
      cnt      <= '0;
      req      <= item.size_value;
      policy_q <= cfg.policy;
      limit_q  <= cfg.limit;
    end else if (issue) begin
      cnt <= cnt + 1'b1;
    end
    if (take) begin
      pick      <= cmp_idx;
      pick_size <= ram_rd_data;
      pick_left <= left;
    end
  end

  assign res_valid = (state == ST_FINISH);

  always_comb begin
    res = '0;
    if (found) begin
      res.allocated        = 1'b1;
      res.chosen_partition = pick;
      res.chosen_size      = pick_size;
      res.leftover         = pick_left;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt <= limit_q))
    else $error("scan counter past limit");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == ST_SCAN))
    else $error("compare outside scan");

  a_pick_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && found) |-> !used[pick])
    else $error("chosen partition already used");

  a_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && found && res_take) |=> used[$past(pick)])
    else $error("chosen partition not marked used");

endmodule

`default_nettype wire
